/* hw/rtl/frwl_pkg.sv */
// ----------------------------------------------------------------------------
// Reader-writer lock package
// Shared constants and status codes of the fair reader-writer lock.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int unsigned MaxReaders = 8;
  localparam int unsigned WaitDepth  = 8;
  localparam int unsigned IdBits     = 8;
  localparam int unsigned MaxResults = 9;

  localparam logic [1:0] OpAcquire = 2'd0;
  localparam logic [1:0] OpTry     = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;
  localparam logic [1:0] OpClose   = 2'd3;

  localparam logic [2:0] StGranted  = 3'd0;
  localparam logic [2:0] StQueued   = 3'd1;
  localparam logic [2:0] StBusy     = 3'd2;
  localparam logic [2:0] StDeadlock = 3'd3;
  localparam logic [2:0] StNotHeld  = 3'd4;
  localparam logic [2:0] StReleased = 3'd5;
  localparam logic [2:0] StFull     = 3'd6;

endpackage

/* hw/rtl/fifo_reader_writer_lock.sv */
// ----------------------------------------------------------------------------
// Fair reader-writer lock
// Grants shared and exclusive locks in ticket order with a waiter memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request that gives a single result
// offers its beat from S_OUT after S_EXEC. A release or close that frees a
// lock first reads the head of the waiter memory through a registered read
// port, so its released beat is offered after the states S_RDQ and S_GRANT.
// Each granted waiter then passes through S_RDQ and S_GRANT again, unless
// the grant is known to be the last because it is a writer, empties the
// queue or reaches the grant limit. Result-side stalls delay these beats.
// The reader table is a register file searched combinationally. A new request
// is accepted in the cycle after the previous request's last beat is taken.
module fifo_reader_writer_lock #(
  parameter int unsigned MAX_READERS = frwl_pkg::MaxReaders,
  parameter int unsigned WAIT_DEPTH  = frwl_pkg::WaitDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: opcode[1:0], requester[9:2], want_write[10], zeros.
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: subject[7:0], status[10:8], as_writer[11], zeros.
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned ID_BITS = frwl_pkg::IdBits;
  localparam int unsigned RdW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int unsigned QW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned RcW  = $clog2(MAX_READERS + 1);
  localparam int unsigned QfW  = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned GntW = $clog2(frwl_pkg::MaxResults);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_OUT, S_RDQ, S_GRANT, S_GOUT
  } state_e;

  state_e state_q;

  logic [1:0]         op_q;
  logic [ID_BITS-1:0] id_q;
  logic               w_q;

  logic               writer_held_q;
  logic [ID_BITS-1:0] writer_owner_q;
  logic [RcW-1:0]     reader_count_q;
  logic [ID_BITS-1:0] rd_owner_q [MAX_READERS];
  logic [MAX_READERS-1:0] rd_valid_q;

  logic [ID_BITS:0]   wq_mem [WAIT_DEPTH];
  logic [ID_BITS:0]   wq_rdata_q;
  logic [QW-1:0]      head_q, tail_q;
  logic [QfW-1:0]     fill_q;
  logic [GntW-1:0]    gcnt_q;

  logic [7:0] out_subj_q;
  logic [2:0] out_st_q;
  logic       out_w_q;
  logic       out_last_q;
  logic       out_valid_q;

  // Reader table search.
  logic             free_found, own_found;
  logic [RdW-1:0]   free_idx, own_idx;

  always_comb begin
    free_found = 1'b0;
    own_found  = 1'b0;
    free_idx   = '0;
    own_idx    = '0;
    for (int i = MAX_READERS - 1; i >= 0; i--) begin
      if (!rd_valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = RdW'(i);
      end
      if (rd_valid_q[i] && rd_owner_q[i] == id_q) begin
        own_found = 1'b1;
        own_idx   = RdW'(i);
      end
    end
  end

  logic             gw;
  logic [ID_BITS-1:0] gid;
  logic             can_now, can_head, more;

  assign gw  = wq_rdata_q[ID_BITS];
  assign gid = wq_rdata_q[ID_BITS-1:0];

  always_comb begin
    can_now = !writer_held_q && (w_q ? (reader_count_q == '0) : free_found);
    can_head = !writer_held_q && (gw ? (reader_count_q == '0) : free_found);
  end

  assign more = (fill_q != '0) && (gcnt_q != GntW'(frwl_pkg::MaxResults - 1));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_w_q, out_st_q, out_subj_q};
  assign m_axis_tlast_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && op_q == frwl_pkg::OpAcquire &&
        !((writer_held_q && writer_owner_q == id_q) || (w_q && own_found)) &&
        !(fill_q == '0 && can_now) && fill_q != QfW'(WAIT_DEPTH)) begin
      wq_mem[tail_q] <= {w_q, id_q};
    end
    wq_rdata_q <= wq_mem[head_q];
    if (state_q == S_EXEC) begin
      if ((op_q == frwl_pkg::OpAcquire || op_q == frwl_pkg::OpTry) && !w_q &&
          fill_q == '0 && can_now &&
          !(op_q == frwl_pkg::OpAcquire && writer_held_q && writer_owner_q == id_q)) begin
        rd_owner_q[free_idx] <= id_q;
      end
    end
    if (state_q == S_GRANT && can_head && !gw) begin
      rd_owner_q[free_idx] <= gid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= '0;
      id_q           <= '0;
      w_q            <= 1'b0;
      writer_held_q  <= 1'b0;
      writer_owner_q <= '0;
      reader_count_q <= '0;
      rd_valid_q     <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      fill_q         <= '0;
      gcnt_q         <= '0;
      out_subj_q     <= '0;
      out_st_q       <= '0;
      out_w_q        <= 1'b0;
      out_last_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q    <= s_axis_tdata_i[1:0];
            id_q    <= s_axis_tdata_i[2 +: ID_BITS];
            w_q     <= s_axis_tdata_i[10];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_subj_q  <= 8'(id_q);
          out_w_q     <= w_q;
          out_valid_q <= 1'b1;
          out_last_q  <= 1'b1;
          gcnt_q      <= '0;
          state_q     <= S_OUT;
          case (op_q)
            frwl_pkg::OpAcquire, frwl_pkg::OpTry: begin
              if (op_q == frwl_pkg::OpAcquire &&
                  ((writer_held_q && writer_owner_q == id_q) || (w_q && own_found))) begin
                out_st_q <= frwl_pkg::StDeadlock;
              end else if (fill_q == '0 && can_now) begin
                out_st_q <= frwl_pkg::StGranted;
                if (w_q) begin
                  writer_held_q  <= 1'b1;
                  writer_owner_q <= id_q;
                end else begin
                  rd_valid_q[free_idx] <= 1'b1;
                  reader_count_q       <= reader_count_q + 1'b1;
                end
              end else if (op_q == frwl_pkg::OpTry) begin
                out_st_q <= frwl_pkg::StBusy;
              end else if (fill_q == QfW'(WAIT_DEPTH)) begin
                out_st_q <= frwl_pkg::StFull;
              end else begin
                out_st_q <= frwl_pkg::StQueued;
                tail_q   <= (tail_q == QW'(WAIT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                fill_q   <= fill_q + 1'b1;
              end
            end
            default: begin
              if (w_q ? (writer_held_q && writer_owner_q == id_q) : own_found) begin
                out_st_q <= frwl_pkg::StReleased;
                if (w_q) begin
                  writer_held_q  <= 1'b0;
                  writer_owner_q <= '0;
                end else begin
                  rd_valid_q[own_idx] <= 1'b0;
                  reader_count_q      <= reader_count_q - 1'b1;
                end
                out_last_q <= 1'b0;
                out_valid_q <= 1'b0;
                state_q     <= S_RDQ;
              end else begin
                out_st_q <= (op_q == frwl_pkg::OpRelease) ? frwl_pkg::StNotHeld
                                                          : frwl_pkg::StReleased;
              end
            end
          endcase
        end
        S_RDQ: begin
          // Head entry is read this cycle; decide once it is registered.
          state_q <= S_GRANT;
        end
        S_GRANT: begin
          if (more && can_head) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b0;
            state_q     <= S_GOUT;
          end else begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_GOUT: begin
          if (m_axis_tready_i) begin
            // Previous beat delivered; current head is granted.
            out_subj_q <= 8'(gid);
            out_st_q   <= frwl_pkg::StGranted;
            out_w_q    <= gw;
            if (gw) begin
              writer_held_q  <= 1'b1;
              writer_owner_q <= gid;
            end else begin
              rd_valid_q[free_idx] <= 1'b1;
              reader_count_q       <= reader_count_q + 1'b1;
            end
            head_q <= (head_q == QW'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
            fill_q <= fill_q - 1'b1;
            gcnt_q <= gcnt_q + 1'b1;
            if (gw || (fill_q == QfW'(1)) ||
                (gcnt_q == GntW'(frwl_pkg::MaxResults - 2))) begin
              out_last_q  <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else begin
              // The next head decides whether this grant is the last beat.
              out_last_q  <= 1'b0;
              out_valid_q <= 1'b0;
              state_q     <= S_RDQ;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Reader-writer lock testbench
// Drives lock requests into the fair reader-writer lock, predicts every
// result beat from its own model of holders and waiters, and compares the
// beats in order, with the stream sides idling at random in some phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] subject;
    logic [2:0] status;
    logic       as_writer;
    logic       last;
  } lock_result_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] requester;
    logic       want_write;
  } lock_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  fifo_reader_writer_lock i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // Predicted lock state.
  logic       wr_held;
  logic [7:0] wr_owner;
  int         rd_count;
  logic [7:0] rd_owner [frwl_pkg::MaxReaders];
  logic       rd_valid [frwl_pkg::MaxReaders];
  logic [8:0] waiters [$];

  lock_req_t    pending_reqs [$];
  lock_result_t expected_beats [$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  failed = 1'b0;
  bit  hold_off = 1'b0;
  longint cycles = 0;

  function automatic int free_rd_slot();
    for (int i = 0; i < frwl_pkg::MaxReaders; i++) if (!rd_valid[i]) return i;
    return -1;
  endfunction

  function automatic int rd_slot_of(logic [7:0] id);
    for (int i = 0; i < frwl_pkg::MaxReaders; i++)
      if (rd_valid[i] && rd_owner[i] == id) return i;
    return -1;
  endfunction

  function automatic bit grantable(logic w);
    if (wr_held) return 1'b0;
    if (w) return rd_count == 0;
    return free_rd_slot() >= 0;
  endfunction

  function automatic void take_lock(logic [7:0] id, logic w);
    int s;
    if (w) begin
      wr_held = 1'b1;
      wr_owner = id;
    end else begin
      s = free_rd_slot();
      rd_owner[s] = id;
      rd_valid[s] = 1'b1;
      rd_count++;
    end
  endfunction

  function automatic void push_beat(ref lock_result_t beats[$], input logic [7:0] id,
                                    input logic [2:0] st, input logic w);
    lock_result_t r;
    if (beats.size() >= frwl_pkg::MaxResults) return;
    r = '{subject: id, status: st, as_writer: w, last: 1'b0};
    beats.push_back(r);
  endfunction

  function automatic bit drop_lock(logic [7:0] id, logic w);
    int s;
    if (w) begin
      if (wr_held && wr_owner == id) begin
        wr_held = 1'b0;
        wr_owner = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    s = rd_slot_of(id);
    if (s < 0) return 1'b0;
    rd_valid[s] = 1'b0;
    rd_owner[s] = '0;
    if (rd_count > 0) rd_count--;
    return 1'b1;
  endfunction

  function automatic void predict_lock(lock_req_t q);
    lock_result_t beats [$];
    logic [8:0] e;
    if (q.opcode == frwl_pkg::OpAcquire) begin
      if ((wr_held && wr_owner == q.requester) ||
          (q.want_write && rd_slot_of(q.requester) >= 0))
        push_beat(beats, q.requester, frwl_pkg::StDeadlock, q.want_write);
      else if (waiters.size() == 0 && grantable(q.want_write)) begin
        take_lock(q.requester, q.want_write);
        push_beat(beats, q.requester, frwl_pkg::StGranted, q.want_write);
      end else if (waiters.size() >= frwl_pkg::WaitDepth)
        push_beat(beats, q.requester, frwl_pkg::StFull, q.want_write);
      else begin
        waiters.push_back({q.want_write, q.requester});
        push_beat(beats, q.requester, frwl_pkg::StQueued, q.want_write);
      end
    end else if (q.opcode == frwl_pkg::OpTry) begin
      if (waiters.size() == 0 && grantable(q.want_write)) begin
        take_lock(q.requester, q.want_write);
        push_beat(beats, q.requester, frwl_pkg::StGranted, q.want_write);
      end else
        push_beat(beats, q.requester, frwl_pkg::StBusy, q.want_write);
    end else if (drop_lock(q.requester, q.want_write)) begin
      push_beat(beats, q.requester, frwl_pkg::StReleased, q.want_write);
      while (waiters.size() > 0 && beats.size() < frwl_pkg::MaxResults) begin
        e = waiters[0];
        if (!grantable(e[8])) break;
        take_lock(e[7:0], e[8]);
        void'(waiters.pop_front());
        push_beat(beats, e[7:0], frwl_pkg::StGranted, e[8]);
        if (e[8]) break;
      end
    end else
      push_beat(beats, q.requester,
                q.opcode == frwl_pkg::OpRelease ? frwl_pkg::StNotHeld : frwl_pkg::StReleased,
                q.want_write);
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[i]) expected_beats.push_back(beats[i]);
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL fifo_reader_writer_lock");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk_i) begin
    lock_req_t q;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_lock(pending_reqs.pop_front());
      end
      if ((!s_axis_tvalid_i || s_axis_tready_o)) begin
        if (pending_reqs.size() > 0 && !hold_off && $urandom_range(99) >= send_idle_pct) begin
          q = pending_reqs[0];
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {5'd0, q.want_write, q.requester, q.opcode};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    lock_result_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = '{subject: m_axis_tdata_o[7:0], status: m_axis_tdata_o[10:8],
                as_writer: m_axis_tdata_o[11], last: m_axis_tlast_o};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %p", $time, got);
          failed = 1'b1;
        end else begin
          exp_r = expected_beats.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
            failed = 1'b1;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_req(logic [1:0] op, logic [7:0] id, logic w);
    lock_req_t q;
    q = '{opcode: op, requester: id, want_write: w};
    pending_reqs.push_back(q);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_beats.size() > 0)
      @(posedge clk_i);
  endtask

  // Mostly a small pool of ids so that holds, waits and releases meet.
  task automatic add_random(int count);
    logic [7:0] id;
    for (int i = 0; i < count; i++) begin
      id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      add_req(2'($urandom_range(3)), id, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    wr_held = 1'b0;
    wr_owner = '0;
    rd_count = 0;
    foreach (rd_valid[i]) begin
      rd_valid[i] = 1'b0;
      rd_owner[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(frwl_pkg::OpRelease, 8'd0, 1'b1);
    add_req(frwl_pkg::OpClose, 8'd255, 1'b0);
    add_req(frwl_pkg::OpAcquire, 8'd255, 1'b1);
    add_req(frwl_pkg::OpAcquire, 8'd255, 1'b0);
    add_req(frwl_pkg::OpTry, 8'd1, 1'b0);
    for (int i = 0; i < 9; i++) add_req(frwl_pkg::OpAcquire, 8'(i + 1), i[0]);
    add_req(frwl_pkg::OpClose, 8'd255, 1'b1);
    for (int i = 0; i < 8; i++) add_req(frwl_pkg::OpRelease, 8'(i + 1), i[0]);
    add_req(frwl_pkg::OpAcquire, 8'd0, 1'b0);
    add_req(frwl_pkg::OpAcquire, 8'd0, 1'b0);
    add_req(frwl_pkg::OpAcquire, 8'd0, 1'b1);
    drain();
    hold_off = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_off = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        3: begin send_idle_pct = 16; recv_stall_pct = 16; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      add_random(85);
      drain();
    end
    repeat (50) @(posedge clk_i);
    if (!failed && expected_beats.size() == 0) begin
      $display("PASS fifo_reader_writer_lock");
    end else begin
      $display("FAIL fifo_reader_writer_lock");
    end
    $finish;
  end
endmodule
